// ===== rtl/core/mtwg_pkg.sv =====
// Shared constants, types and word functions of the Mersenne Twister generator.
`default_nettype none
package mtwg_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned KIND_W        = 2;

  localparam logic [IDX_W-1:0] POS_TWIST    = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] POS_UNSEEDED = IDX_W'(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(STATE_WORDS - 1);

  localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

  typedef enum logic [KIND_W-1:0] {
    KIND_DRAW   = 2'd0,
    KIND_RESEED = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_DRAW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic push;
    logic last;
  } seed_stat_t;

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mersenne_twister_word_generator.sv =====
// MT19937 word generator: a 624-cell shift chain twisted one word per draw.
// Draw: result registered in the cycle after acceptance; one draw per cycle while results are taken.
// Reseed: the seeding unit fills all 624 cells (two LCG steps per word) before the next request.
// First draw before any seeding runs the same fill first; a load at read position p
// below 624 first advances the chain up to position 624, then writes the word.
// Reset clears control, marks the generator unseeded and sets the seed register to 4357.
`default_nettype none
module mersenne_twister_word_generator
  import mtwg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [IDX_W-1:0]  in_word_index,
  input  wire logic [WORD_W-1:0] in_load_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] out_random_word
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] seed_r;
  logic              draw_pend_r, draw_pend_nxt;
  logic [IDX_W-1:0]  ld_idx_r, ld_idx_nxt;
  logic [WORD_W-1:0] ld_word_r, ld_word_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic [WORD_W-1:0] chain [STATE_WORDS];
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] shift_in;
  logic              shift_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [WORD_W-1:0] wr_word;

  logic              in_acc;
  logic              out_free;
  logic              idx_ok;
  logic              draw_go;
  logic              seed_start;
  logic [WORD_W-1:0] seed_sel;
  logic              load_now;
  logic              finish_go;
  logic              finish_shift;
  logic              finish_wr;
  logic [WORD_W-1:0] seed_word;
  seed_stat_t        seed_stat;

  assign new_word = twist_word(chain[0], chain[1], chain[MIDDLE_OFFSET]);
  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = in_word_index < POS_TWIST;

  always_comb begin
    in_stall     = (state_r != ST_IDLE) || !out_free;
    draw_go      = 1'b0;
    seed_start   = 1'b0;
    seed_sel     = seed_r;
    load_now     = 1'b0;
    finish_go    = 1'b0;
    finish_shift = 1'b0;
    finish_wr    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_t'(in_kind))
            KIND_DRAW: begin
              if (pos_r == POS_UNSEEDED) begin
                seed_start = 1'b1;
                seed_sel   = DEFAULT_SEED;
              end else begin
                draw_go = 1'b1;
              end
            end
            KIND_RESEED: seed_start = 1'b1;
            KIND_LOAD: begin
              if (idx_ok) begin
                if (pos_r >= POS_TWIST) begin
                  load_now = 1'b1;
                end else begin
                  finish_go = 1'b1;
                end
              end
            end
            KIND_NONE: ;
            default: ;
          endcase
        end
      end
      ST_SEED: ;
      ST_DRAW: draw_go = out_free;
      ST_FINISH: begin
        finish_shift = (pos_r != POS_TWIST);
        finish_wr    = (pos_r == POS_TWIST);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (seed_start) begin
          state_nxt = ST_SEED;
        end else if (finish_go) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SEED: begin
        if (seed_stat.last) begin
          state_nxt = draw_pend_r ? ST_DRAW : ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (pos_r == POS_TWIST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign shift_en = draw_go || finish_shift || seed_stat.push;
  assign shift_in = seed_stat.push ? seed_word : new_word;
  assign wr_en    = load_now || finish_wr;
  assign wr_idx   = load_now ? in_word_index : ld_idx_r;
  assign wr_word  = load_now ? in_load_word : ld_word_r;

  always_comb begin
    pos_nxt       = pos_r;
    draw_pend_nxt = draw_pend_r;
    ld_idx_nxt    = ld_idx_r;
    ld_word_nxt   = ld_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (seed_start) begin
      draw_pend_nxt = (kind_t'(in_kind) == KIND_DRAW);
    end
    if (finish_go) begin
      ld_idx_nxt  = in_word_index;
      ld_word_nxt = in_load_word;
    end
    if (seed_stat.last || wr_en) begin
      pos_nxt = POS_TWIST;
    end else if (draw_go) begin
      pos_nxt = (pos_r >= POS_TWIST) ? IDX_W'(1) : pos_r + 1'b1;
    end else if (finish_shift) begin
      pos_nxt = pos_r + 1'b1;
    end
    if (draw_go) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = temper(new_word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_UNSEEDED;
      seed_r      <= DEFAULT_SEED;
      draw_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      draw_pend_r <= draw_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r   <= ld_idx_nxt;
    ld_word_r  <= ld_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  mtwg_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_start),
    .seed  (seed_sel),
    .word  (seed_word),
    .stat  (seed_stat)
  );

  for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
    logic [WORD_W-1:0] cell_in;
    if (g == STATE_WORDS - 1) begin : g_tail
      assign cell_in = shift_in;
    end else begin : g_body
      assign cell_in = chain[g+1];
    end
    mtwg_cell #(
      .CELL_IDX (IDX_W'(g))
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (cell_in),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_word  (wr_word),
      .word     (chain[g])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/mtwg_cell.sv =====
// One state word cell of the shift chain, with an indexed write port.
`default_nettype none
module mtwg_cell
  import mtwg_pkg::*;
#(
  parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [WORD_W-1:0] shift_in,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [WORD_W-1:0] wr_word,
  output logic      [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (shift_en) begin
      word_nxt = shift_in;
    end else if (wr_en && (wr_idx == CELL_IDX)) begin
      word_nxt = wr_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule
`default_nettype wire

// ===== rtl/core/mtwg_seeder.sv =====
// LCG seeding unit: produces the state words from a seed, each from the high halves of consecutive LCG values.
`default_nettype none
module mtwg_seeder
  import mtwg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] seed,
  output logic      [WORD_W-1:0] word,
  output seed_stat_t             stat
);

  logic              active_r, active_nxt;
  logic              phase_r, phase_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] lcg_r, lcg_nxt;
  logic [15:0]       hi_r, hi_nxt;
  logic [WORD_W-1:0] prod;

  assign prod      = lcg_r * LCG_MULT + 32'd1;
  assign word      = {hi_r, lcg_r[31:16]};
  assign stat.push = active_r && phase_r;
  assign stat.last = active_r && phase_r && (cnt_r == LAST_IDX);

  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    lcg_nxt    = lcg_r;
    hi_nxt     = hi_r;
    if (start) begin
      active_nxt = 1'b1;
      phase_nxt  = 1'b0;
      cnt_nxt    = '0;
      lcg_nxt    = seed;
    end else if (active_r) begin
      lcg_nxt   = prod;
      phase_nxt = ~phase_r;
      if (!phase_r) begin
        hi_nxt = lcg_r[31:16];
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_r <= lcg_nxt;
    hi_r  <= hi_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_mersenne_twister_word_generator.sv =====
// Self-checking testbench for the MT19937 word generator: predicts every drawn word and compares.
`default_nettype none
module tb_mersenne_twister_word_generator;
  import mtwg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 1300;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  kind_t             in_kind;
  logic [IDX_W-1:0]  in_word_index;
  logic [WORD_W-1:0] in_load_word;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_random_word;

  logic [WORD_W-1:0] mt_words [STATE_WORDS];
  logic [IDX_W-1:0]  mt_pos;
  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] pending_words [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  int unsigned sink_left      = 0;
  bit          sink_stalling  = 1'b0;
  bit          idling_on      = 1'b1;

  mersenne_twister_word_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_word_index   (in_word_index),
    .in_load_word    (in_load_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void seed_words(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] lcg;
    int unsigned       k;
    lcg = seed;
    for (k = 0; k < STATE_WORDS; k++) begin
      mt_words[k][31:16] = lcg[31:16];
      lcg = lcg * LCG_MULT + 32'd1;
      mt_words[k][15:0] = lcg[31:16];
      lcg = lcg * LCG_MULT + 32'd1;
    end
    mt_pos = POS_TWIST;
  endfunction

  function automatic void regenerate_words();
    logic [WORD_W-1:0] mixed;
    int unsigned       k;
    for (k = 0; k < STATE_WORDS; k++) begin
      mixed = {mt_words[k][31], mt_words[(k + 1) % STATE_WORDS][30:0]};
      mt_words[k] = mt_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ {1'b0, mixed[31:1]}
                    ^ (mixed[0] ? TWIST_XOR : '0);
    end
    mt_pos = '0;
  endfunction

  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw ^ {11'b0, raw[31:11]};
    t = t ^ ({t[24:0], 7'b0} & TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & TEMPER_C);
    return t ^ {18'b0, t[31:18]};
  endfunction

  function automatic void apply_request(input kind_t kind, input logic [IDX_W-1:0] idx,
                                        input logic [WORD_W-1:0] word);
    case (kind)
      KIND_RESEED: begin
        seed_words(seed_reg);
      end
      KIND_LOAD: begin
        if (idx < STATE_WORDS) begin
          mt_words[idx] = word;
          mt_pos = POS_TWIST;
        end
      end
      KIND_DRAW: begin
        if (mt_pos >= STATE_WORDS) begin
          if (mt_pos == POS_UNSEEDED) begin
            seed_words(DEFAULT_SEED);
          end
          regenerate_words();
        end
        pending_words.push_back(tempered(mt_words[mt_pos]));
        mt_pos = mt_pos + 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pause_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned run_length();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 12);
    end
    return $urandom_range(40, 120);
  endfunction

  function automatic int unsigned sender_gap();
    if (!idling_on || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pause_length();
  endfunction

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      sink_left = 0;
      sink_stalling = 1'b1;
      out_stall <= 1'b1;
    end else if (!idling_on) begin
      sink_left = 0;
      sink_stalling = 1'b0;
      out_stall <= 1'b0;
    end else if (sink_left != 0) begin
      sink_left = sink_left - 1;
    end else begin
      sink_stalling = !sink_stalling;
      out_stall <= sink_stalling;
      sink_left = sink_stalling ? pause_length() - 1 : run_length() - 1;
    end
  end

  always @(posedge clk) begin : monitor_proc
    logic [WORD_W-1:0] want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        apply_request(in_kind, in_word_index, in_load_word);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected random_word %08h with no draw pending", out_random_word);
          end
        end else begin
          want = pending_words.pop_front();
          if (out_random_word !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("random_word mismatch: expected %08h, got %08h", want, out_random_word);
            end
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mersenne_twister_word_generator verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(input kind_t kind, input logic [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] word);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_word_index <= idx;
    in_load_word  <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_draws(input int unsigned count);
    repeat (count) send_request(KIND_DRAW, IDX_W'($urandom), $urandom);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    seed_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    // unknown kind and out-of-range load before seeding: both dropped
    send_request(KIND_NONE, 10'h3ff, 32'hffffffff);
    send_request(KIND_LOAD, 10'h3ff, 32'h00000000);
    // first draw seeds with the default seed
    send_request(KIND_DRAW, 10'h000, 32'h00000000);
    send_request(KIND_DRAW, 10'h3ff, 32'hffffffff);
    send_request(KIND_RESEED, 10'h000, 32'h00000000);
    send_draws(2);
    send_request(KIND_LOAD, 10'd0, 32'h00000000);
    send_request(KIND_LOAD, LAST_IDX, 32'hffffffff);
    send_request(KIND_LOAD, POS_TWIST, 32'h12345678);
    send_draws(2);
    send_request(KIND_NONE, 10'h000, 32'h00000000);
    send_draws(1);
    settle();
    write_seed(32'h00000000);
    send_request(KIND_RESEED, 10'h155, 32'h55555555);
    send_draws(2);
    settle();
    write_seed(32'hffffffff);
    send_request(KIND_RESEED, 10'h2aa, 32'haaaaaaaa);
    send_draws(2);
  endtask

  task automatic test_long_run();
    settle();
    write_seed($urandom);
    send_request(KIND_RESEED, IDX_W'($urandom), $urandom);
    send_draws(650);
  endtask

  task automatic test_backpressure();
    drain_results();
    idling_on = 1'b0;
    hold_left = 400;
    send_draws(60);
    drain_results();
    idling_on = 1'b1;
  endtask

  task automatic test_mixed_random();
    int unsigned counted;
    int unsigned pick;
    int unsigned n;
    counted = 0;
    while (counted < 150) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(1, 8);
        send_draws(n);
        counted += n;
      end else if (pick < 72) begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(KIND_LOAD, IDX_W'($urandom_range(0, STATE_WORDS - 1)), $urandom);
        counted += n;
        n = $urandom_range(1, 6);
        send_draws(n);
        counted += n;
      end else if (pick < 80) begin
        send_request(KIND_RESEED, IDX_W'($urandom), $urandom);
        n = $urandom_range(1, 10);
        send_draws(n);
        counted += n + 1;
      end else if (pick < 84) begin
        settle();
        write_seed($urandom);
        send_request(KIND_RESEED, IDX_W'($urandom), $urandom);
        counted++;
      end else if (pick < 92) begin
        send_request(KIND_NONE, IDX_W'($urandom), $urandom);
      end else begin
        send_request(KIND_LOAD, IDX_W'($urandom_range(STATE_WORDS, 1023)), $urandom);
      end
    end
  endtask

  task automatic test_steady_flow();
    drain_results();
    idling_on = 1'b0;
    send_draws(40);
    drain_results();
    idling_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_kind       = KIND_DRAW;
    in_word_index = '0;
    in_load_word  = '0;
    seed_reg      = DEFAULT_SEED;
    mt_pos        = POS_UNSEEDED;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_long_run();
    test_backpressure();
    test_mixed_random();
    test_steady_flow();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("mersenne_twister_word_generator verification clean");
    end else begin
      $display("mersenne_twister_word_generator verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/mtwg_pkg.sv
rtl/core/mtwg_cell.sv
rtl/core/mtwg_seeder.sv
rtl/core/mersenne_twister_word_generator.sv
tb/sv/tb_mersenne_twister_word_generator.sv
